@@ rtl/core/kthbl_pkg.sv @@
// Shared constants, types and helpers for the k-th successor binary lifting core.
package kthbl_pkg;

  // Node count and number of doubling levels.
  localparam int NODES  = 1024;
  localparam int LEVELS = 31;

  // Field and address widths.
  localparam int NODE_W    = 10;
  localparam int STEPS_W   = 31;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int IDX_W     = NODE_W + 1;
  localparam int ADDR_W    = LVL_W + NODE_W;
  localparam int TBL_DEPTH = LEVELS * NODES;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((2 * NODE_W + STEPS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NODE_W + 7) / 8) * 8;

  // Item kinds carried on the input tuser.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_REBUILD = 6'b000100,
    ST_QUERY   = 6'b001000,
    ST_FINISH  = 6'b010000,
    ST_SPARE   = 6'b100000
  } state_t;

  // Access request from the sequencer to the lifting table.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic              re_a;
    logic [ADDR_W-1:0] raddr_a;
    logic              re_b;
    logic [ADDR_W-1:0] raddr_b;
  } tbl_req_t;

  // Map a node index that lies beyond the node count to node zero.
  function automatic logic [NODE_W-1:0] node_safe(input logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] res;
    res = (int'(v) < NODES) ? v : '0;
    return res;
  endfunction

  // True when a node index lies inside the node range.
  function automatic logic node_ok(input logic [NODE_W-1:0] v);
    logic res;
    res = (int'(v) < NODES);
    return res;
  endfunction

endpackage

@@ rtl/core/kthbl_table.sv @@
// Lifting table memory: one write port and two registered read ports.
module kthbl_table
  import kthbl_pkg::*;
(
  input  logic              clk,
  input  tbl_req_t          req,
  output logic [NODE_W-1:0] rdata_a,
  output logic [NODE_W-1:0] rdata_b
);

  // Entry for level l and node n sits at address {l, n}.
  logic [NODE_W-1:0] mem [TBL_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read ports hold their data until the next read on the same port.
  always_ff @(posedge clk) begin
    if (req.re_a) begin
      rdata_a <= mem[req.raddr_a];
    end
    if (req.re_b) begin
      rdata_b <= mem[req.raddr_b];
    end
  end

endmodule

@@ rtl/core/kthbl_engine.sv @@
// Sequencer: level-zero clear, load writes, level rebuild and the query walk.
module kthbl_engine
  import kthbl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [NODE_W-1:0]  in_node,
  input  logic [NODE_W-1:0]  in_succ,
  input  logic [STEPS_W-1:0] in_steps,
  input  logic               res_free,
  output logic               res_valid,
  output logic [NODE_W-1:0]  res_target,
  output tbl_req_t           tbl_req,
  input  logic [NODE_W-1:0]  rdata_a,
  input  logic [NODE_W-1:0]  rdata_b
);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic               s1_v_r, s1_v_nxt;
  logic [NODE_W-1:0]  s1_idx_r, s1_idx_nxt;
  logic               s2_v_r, s2_v_nxt;
  logic [NODE_W-1:0]  s2_idx_r, s2_idx_nxt;
  logic [LVL_W-1:0]   bit_r, bit_nxt;
  logic               pend_r, pend_nxt;
  logic [NODE_W-1:0]  cur_r, cur_nxt;
  logic               oor_r, oor_nxt;
  logic [STEPS_W-1:0] steps_r, steps_nxt;
  logic               stale_r, stale_nxt;

  logic               accept;
  logic               issue;
  logic [LVL_W-1:0]   lvl_prev;
  logic [NODE_W-1:0]  cur_eff;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign lvl_prev = lvl_r - LVL_W'(1);
  assign issue    = (idx_r != IDX_W'(NODES));

  // The walk position is the last table read when one is pending.
  assign cur_eff = pend_r ? node_safe(rdata_a) : cur_r;

  // Next-state and table access logic.
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    lvl_nxt    = lvl_r;
    s1_v_nxt   = 1'b0;
    s1_idx_nxt = s1_idx_r;
    s2_v_nxt   = 1'b0;
    s2_idx_nxt = s2_idx_r;
    bit_nxt    = bit_r;
    pend_nxt   = pend_r;
    cur_nxt    = cur_r;
    oor_nxt    = oor_r;
    steps_nxt  = steps_r;
    stale_nxt  = stale_r;
    tbl_req    = '0;
    res_valid  = 1'b0;
    res_target = oor_r ? '0 : cur_eff;

    case (state_r)
      // Sweep level zero to node zero after reset.
      ST_CLEAR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = {LVL_W'(0), idx_r[NODE_W-1:0]};
        tbl_req.wdata = '0;
        idx_nxt       = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(NODES - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      // Take a load directly into level zero, or start a query.
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            if (node_ok(in_node) && node_ok(in_succ)) begin
              tbl_req.we    = 1'b1;
              tbl_req.waddr = {LVL_W'(0), in_node};
              tbl_req.wdata = in_succ;
              stale_nxt     = 1'b1;
            end
          end else begin
            oor_nxt   = !node_ok(in_node);
            steps_nxt = in_steps;
            cur_nxt   = in_node;
            pend_nxt  = 1'b0;
            bit_nxt   = '0;
            if (stale_r) begin
              lvl_nxt   = LVL_W'(1);
              idx_nxt   = '0;
              state_nxt = ST_REBUILD;
            end else begin
              state_nxt = ST_QUERY;
            end
          end
        end
      end

      // Three-stage pipe per level: read mid, read mid's entry, write.
      ST_REBUILD: begin
        if (issue) begin
          tbl_req.re_a    = 1'b1;
          tbl_req.raddr_a = {lvl_prev, idx_r[NODE_W-1:0]};
          idx_nxt         = idx_r + IDX_W'(1);
        end
        s1_v_nxt   = issue;
        s1_idx_nxt = idx_r[NODE_W-1:0];
        if (s1_v_r) begin
          tbl_req.re_b    = 1'b1;
          tbl_req.raddr_b = {lvl_prev, node_safe(rdata_a)};
        end
        s2_v_nxt   = s1_v_r;
        s2_idx_nxt = s1_idx_r;
        if (s2_v_r) begin
          tbl_req.we    = 1'b1;
          tbl_req.waddr = {lvl_r, s2_idx_r};
          tbl_req.wdata = rdata_b;
        end
        // A level starts only once the previous one is fully written.
        if (!issue && !s1_v_r && !s2_v_r) begin
          if (lvl_r == LVL_W'(LEVELS - 1)) begin
            stale_nxt = 1'b0;
            state_nxt = ST_QUERY;
          end else begin
            lvl_nxt = lvl_r + LVL_W'(1);
            idx_nxt = '0;
          end
        end
      end

      // One level per cycle; a set step bit reads that level at the walk position.
      ST_QUERY: begin
        if (steps_r[bit_r]) begin
          tbl_req.re_a    = 1'b1;
          tbl_req.raddr_a = {bit_r, cur_eff};
        end
        pend_nxt = steps_r[bit_r];
        cur_nxt  = cur_eff;
        bit_nxt  = bit_r + LVL_W'(1);
        if (bit_r == LVL_W'(LEVELS - 1)) begin
          state_nxt = ST_FINISH;
        end
      end

      // Hand the target over once the output register is free.
      ST_FINISH: begin
        res_valid = res_free;
        if (res_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      lvl_r   <= LVL_W'(1);
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      bit_r   <= '0;
      pend_r  <= 1'b0;
      stale_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      lvl_r   <= lvl_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      bit_r   <= bit_nxt;
      pend_r  <= pend_nxt;
      stale_r <= stale_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_idx_r <= s1_idx_nxt;
    s2_idx_r <= s2_idx_nxt;
    cur_r    <= cur_nxt;
    oor_r    <= oor_nxt;
    steps_r  <= steps_nxt;
  end

  // The rebuild never overwrites the loaded successor map.
  a_rebuild_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REBUILD && tbl_req.we) |-> (tbl_req.waddr[ADDR_W-1:NODE_W] != '0))
    else $error("rebuild wrote level zero");

  // A result is only produced from fresh tables.
  a_result_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !stale_r)
    else $error("result produced from stale tables");

  // A query that finds stale tables goes through a rebuild first.
  a_stale_query: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_QUERY && stale_r) |=> (state_r == ST_REBUILD))
    else $error("stale query skipped the rebuild");

  // A new level begins with the pipe empty.
  a_level_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REBUILD && $past(state_r == ST_REBUILD) && lvl_r != $past(lvl_r))
      |-> (!s1_v_r && !s2_v_r))
    else $error("level started with accesses in flight");

endmodule

@@ rtl/core/kth_successor_binary_lifting_core.sv @@
// Top level of the k-th successor core: stream ports, output register, engine and table.
//
// The core keeps a successor map over 1024 nodes in a lifting table of 31 levels and
// answers "which node is reached after k steps" queries. A load transaction writes one
// successor and produces no result. A query transaction produces one result: it walks
// the 31 levels one per cycle through the table's read port, and the result is registered.
// The first query after any load first rebuilds levels 1 to 30, each level streamed over
// all nodes through two read ports and one write port at one node per cycle, with the
// pipe drained before the next level starts. After reset the core sweeps all 1024 nodes
// of level zero to node zero and holds in_tready low meanwhile. A zero step count returns
// the queried node. The output register lets the next transaction be accepted while a
// result waits on out_tready.
module kth_successor_binary_lifting_core
  import kthbl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // node [9:0], successor [19:10], steps [50:20]
  input  logic                  in_tuser,   // kind: 0 load, 1 query
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // target [9:0]
);

  logic                  res_free;
  logic                  res_valid;
  logic [NODE_W-1:0]     res_target;
  tbl_req_t              tbl_req;
  logic [NODE_W-1:0]     rdata_a;
  logic [NODE_W-1:0]     rdata_b;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  assign res_free = !out_tvalid_r || out_tready;

  kthbl_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_node    (in_tdata[NODE_W-1:0]),
    .in_succ    (in_tdata[2*NODE_W-1:NODE_W]),
    .in_steps   (in_tdata[2*NODE_W+STEPS_W-1:2*NODE_W]),
    .res_free   (res_free),
    .res_valid  (res_valid),
    .res_target (res_target),
    .tbl_req    (tbl_req),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b)
  );

  kthbl_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Output register for the result transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_tdata_r <= OUT_DATA_W'(res_target);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ verif/tb_kth_successor_binary_lifting_core.sv @@
// Self-checking testbench for the k-th successor binary lifting core.
module tb_kth_successor_binary_lifting_core;
  timeunit 1ns;
  timeprecision 1ps;

  import kthbl_pkg::*;

  // Run limits: cycles without any accepted transaction, and settle time at the end.
  localparam int IDLE_LIMIT   = 150000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [STEPS_W-1:0] ALL_STEPS = '1;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = KIND_LOAD;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Local copy of the doubling table: level j of a node is level j-1 applied twice.
  logic [NODE_W-1:0]     jump [LEVELS][NODES];
  bit                    jumps_stale;
  logic [NODE_W-1:0]     pending_targets [$];
  logic [NODE_W-1:0]     last_loaded;
  int                    fail_count   = 0;
  int                    quiet_cycles = 0;
  int                    in_gap_pct   = 20;
  int                    out_stall_pct = 20;

  always #5 clk = ~clk;

  kth_successor_binary_lifting_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Rebuild the upper levels when a load has touched the map, then walk the set step bits.
  function automatic logic [NODE_W-1:0] predict_landing(input logic [NODE_W-1:0] node,
                                                        input logic [STEPS_W-1:0] steps);
    logic [NODE_W-1:0] cur;
    if (jumps_stale) begin
      for (int lvl = 1; lvl < LEVELS; lvl++) begin
        for (int i = 0; i < NODES; i++) begin
          jump[lvl][i] = jump[lvl-1][jump[lvl-1][i]];
        end
      end
      jumps_stale = 1'b0;
    end
    cur = node;
    for (int b = 0; b < STEPS_W && b < LEVELS; b++) begin
      if (steps[b]) begin
        cur = jump[b][cur];
      end
    end
    return cur;
  endfunction

  // Step counts: zero, short walks, single bits, all ones, whole laps and full-range values.
  function automatic logic [STEPS_W-1:0] pick_steps();
    logic [STEPS_W-1:0] s;
    case ($urandom_range(0, 7))
      0: s = '0;
      1: s = STEPS_W'($urandom_range(1, 20));
      2: s = STEPS_W'(1) << $urandom_range(0, STEPS_W - 1);
      3: s = ALL_STEPS;
      4: s = STEPS_W'(NODES * $urandom_range(1, 8));
      default: s = STEPS_W'($urandom());
    endcase
    return s;
  endfunction

  // Send one input transaction, with an optional gap, and update the prediction on acceptance.
  task automatic send_item(input logic kind, input logic [NODE_W-1:0] node,
                           input logic [NODE_W-1:0] succ, input logic [STEPS_W-1:0] steps);
    logic [IN_DATA_W-1:0] word;
    logic [NODE_W-1:0]    landing;
    word = '0;
    word[NODE_W-1:0]                   = node;
    word[2*NODE_W-1:NODE_W]            = succ;
    word[2*NODE_W+STEPS_W-1:2*NODE_W]  = steps;
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_LOAD) begin
      jump[0][node] = succ;
      jumps_stale   = 1'b1;
      last_loaded   = node;
    end else begin
      landing = predict_landing(node, steps);
      pending_targets.insert(pending_targets.size(), landing);
    end
  endtask

  task automatic load_succ(input logic [NODE_W-1:0] node, input logic [NODE_W-1:0] succ);
    send_item(KIND_LOAD, node, succ, STEPS_W'($urandom()));
  endtask

  task automatic query(input logic [NODE_W-1:0] node, input logic [STEPS_W-1:0] steps);
    send_item(KIND_QUERY, node, NODE_W'($urandom()), steps);
  endtask

  // Queries on the map left by reset, where every node points at node zero.
  task automatic test_reset_map();
    query(0, '0);
    query(NODE_W'(NODES - 1), '0);
    query(NODE_W'(NODES - 1), 1);
    query(512, ALL_STEPS);
  endtask

  // Short cycles and a self loop, then an overwrite that must force a second rebuild.
  task automatic test_small_cycles();
    load_succ(0, NODE_W'(NODES - 1));
    load_succ(NODE_W'(NODES - 1), 0);
    load_succ(1, 2);
    load_succ(2, 3);
    load_succ(3, 1);
    load_succ(1000, 1000);
    query(0, 1);
    query(0, 2);
    query(1, ALL_STEPS);
    query(1000, STEPS_W'(1) << (STEPS_W - 1));
    query(3, 5);
    query(NODE_W'(NODES - 1), 31'h5555_5555);
    query(2, '0);
    query(700, 3);
    load_succ(2, 700);
    query(1, 2);
    query(1, 3);
  endtask

  // One long cycle through all nodes in random order, then many queries on it.
  task automatic test_full_permutation(input int queries);
    int order [NODES];
    int j, tmp;
    for (int i = 0; i < NODES; i++) begin
      order[i] = i;
    end
    for (int i = NODES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NODES; i++) begin
      load_succ(NODE_W'(order[i]), NODE_W'(order[(i + 1) % NODES]));
    end
    repeat (queries) query(NODE_W'($urandom_range(0, NODES - 1)), pick_steps());
  endtask

  // Rounds of a few edits to the map followed by a batch of queries.
  task automatic test_update_rounds(input int rounds, input bit allow_idle);
    int edits;
    logic [NODE_W-1:0] n;
    for (int r = 0; r < rounds; r++) begin
      if (allow_idle) begin
        in_gap_pct    = 15 * $urandom_range(0, 3);
        out_stall_pct = 15 * $urandom_range(0, 3);
      end else begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
      edits = $urandom_range(1, 30);
      repeat (edits) begin
        n = NODE_W'($urandom_range(0, NODES - 1));
        case ($urandom_range(0, 3))
          0: load_succ(n, NODE_W'($urandom()));
          1: load_succ(n, n);
          2: load_succ(n, jump[0][n]);
          default: load_succ(n, n + 1'b1);
        endcase
      end
      repeat ($urandom_range(20, 50)) begin
        if ($urandom_range(0, 3) == 0) begin
          query(last_loaded, pick_steps());
        end else begin
          query(NODE_W'($urandom_range(0, NODES - 1)), pick_steps());
        end
      end
    end
  endtask

  // Output side: ready stalls in random bursts while stalling is enabled.
  initial begin
    forever begin
      if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest predicted target.
  always @(posedge clk) begin : check_targets
    logic [NODE_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_targets.size() == 0) begin
        $display("%0t: result with no query pending, expected none, actual %0d",
                 $time, out_tdata[NODE_W-1:0]);
        fail_count++;
      end else begin
        want = pending_targets.pop_front();
        if (out_tdata[NODE_W-1:0] !== want) begin
          $display("%0t: target mismatch, expected %0d, actual %0d",
                   $time, want, out_tdata[NODE_W-1:0]);
          fail_count++;
        end
      end
    end
  end

  // Stop the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    for (int i = 0; i < NODES; i++) begin
      jump[0][i] = '0;
    end
    jumps_stale = 1'b1;
    last_loaded = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_map();
    test_small_cycles();
    test_full_permutation(150);
    test_update_rounds(8, 1'b1);
    test_update_rounds(2, 1'b0);

    in_tvalid <= 1'b0;
    while (pending_targets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/kthbl_pkg.sv
rtl/core/kthbl_table.sv
rtl/core/kthbl_engine.sv
rtl/core/kth_successor_binary_lifting_core.sv
verif/tb_kth_successor_binary_lifting_core.sv
